@@ src/cete_pkg.sv @@
package cete_pkg;

   localparam int CLIQUE_MAX_DEF = 4;
   localparam int DATA_W         = 32;
   localparam int CSR_W          = 3;
   localparam int CMD_W          = 3;
   localparam int IDX_W          = 4;
   localparam int NODE_W         = 2;
   localparam logic [CSR_W-1:0] CLIQUE_SIZE_RST = 3'd2;
   localparam logic [CSR_W-1:0] NODE_MIN        = 3'd2;
   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 3'd0,
      CMD_RESET = 3'd1,
      CMD_PUSH  = 3'd2,
      CMD_CAP   = 3'd3,
      CMD_NZ    = 3'd4
   } cmd_type;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       use_best;
   } alu_ctrl_type;

endpackage

@@ src/clique_energy_table_engine.sv @@
// Energy table engine for one clique of binary nodes. Commands: load an energy
// entry, copy energy into alpha, push an amount between two nodes, read the
// exchange capacity of an arc, test an arc for nonzero capacity. One command is
// taken at a time and req_stall stays high until its beat is formed. With
// n nodes (2^n entries): load, nonzero test and unknown codes go straight to
// the result; reset alpha makes a copy pass and a scan pass; push makes a push
// pass and a scan pass and exchange capacity one pass when their nodes are in
// range (else straight to the result). Each entry takes a read state and then a
// write or check state in every pass, as the tables sit in RAMs with a registered
// read port and one shared add/compare unit handles one entry at a time. Results
// leave through an output register, so a stalled result delays only the next command's end.
module clique_energy_table_engine #(
   parameter int CLIQUE_MAX = cete_pkg::CLIQUE_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cete_pkg::CMD_W-1:0]          req_command,
   input  logic [cete_pkg::IDX_W-1:0]          req_entry_index,
   input  logic [cete_pkg::NODE_W-1:0]         req_from_node,
   input  logic [cete_pkg::NODE_W-1:0]         req_to_node,
   input  logic signed [cete_pkg::DATA_W-1:0]  req_amount,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cete_pkg::DATA_W-1:0]  rsp_capacity,
   output logic                                rsp_nonzero,
   output logic                                rsp_done_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cete_pkg::CSR_W-1:0]          csr_clique_size
);

   localparam int DEPTH = 1 << CLIQUE_MAX;
   localparam int AW    = CLIQUE_MAX;
   localparam int NW    = $clog2(CLIQUE_MAX);
   localparam int CW    = cete_pkg::CSR_W;
   localparam int DW    = cete_pkg::DATA_W;
   localparam logic [CW-1:0] NODE_MAX = CW'(CLIQUE_MAX);

   typedef enum logic [9:0] {
      IDLE     = 10'b00_0000_0001,
      COPY_RD  = 10'b00_0000_0010,
      COPY_WR  = 10'b00_0000_0100,
      SCAN_RD  = 10'b00_0000_1000,
      SCAN_CHK = 10'b00_0001_0000,
      PUSH_RD  = 10'b00_0010_0000,
      PUSH_WR  = 10'b00_0100_0000,
      CAP_RD   = 10'b00_1000_0000,
      CAP_CHK  = 10'b01_0000_0000,
      FINISH   = 10'b10_0000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             size_ff, size_in;
   logic [AW-1:0]             cnt_ff, cnt_in;
   logic [CLIQUE_MAX-1:0]     tight_ff [CLIQUE_MAX];
   logic [CLIQUE_MAX-1:0]     tight_in [CLIQUE_MAX];
   logic [cete_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [cete_pkg::NODE_W-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [DW-1:0]      amt_ff, amt_in;
   logic                      node_ok_ff, node_ok_in;
   logic signed [DW-1:0]      best_ff, best_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]      rsp_capacity_ff, rsp_capacity_in;
   logic                      rsp_nonzero_ff, rsp_nonzero_in;
   logic                      rsp_done_res_ff, rsp_done_res_in;

   logic [CW-1:0]             node_cnt;
   logic [CLIQUE_MAX-1:0]     full_mask;
   logic                      req_accept;
   logic                      req_node_ok;
   logic [NW-1:0]             u_idx, v_idx;
   logic                      cnt_u, cnt_v;
   logic                      energy_we, alpha_we;
   logic [AW-1:0]             load_addr;
   logic [DW-1:0]             energy_rd, alpha_rd, alpha_wd;
   cete_pkg::alu_ctrl_type    alu_ctrl;
   logic signed [DW-1:0]      alu_sum;
   logic                      alu_less;

   // clamp the clique size into 2..CLIQUE_MAX
   always_comb begin
      if (size_ff < cete_pkg::NODE_MIN) begin
         node_cnt = cete_pkg::NODE_MIN;
      end else if (size_ff > NODE_MAX) begin
         node_cnt = NODE_MAX;
      end else begin
         node_cnt = size_ff;
      end
      for (int i = 0; i < CLIQUE_MAX; i++) begin
         full_mask[i] = CW'(i) < node_cnt;
      end
   end

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = state_ff != IDLE;
   assign req_node_ok = ({1'b0, req_from_node} < node_cnt) && ({1'b0, req_to_node} < node_cnt);
   assign csr_ready   = 1'b1;
   assign load_addr   = AW'(req_entry_index);

   assign u_idx = NW'(u_ff);
   assign v_idx = NW'(v_ff);
   assign cnt_u = cnt_ff[u_idx];
   assign cnt_v = cnt_ff[v_idx];

   assign energy_we = req_accept && (req_command == cete_pkg::CMD_LOAD);
   assign alpha_we  = (state_ff == COPY_WR) || ((state_ff == PUSH_WR) && (cnt_u != cnt_v));
   assign alpha_wd  = (state_ff == COPY_WR) ? energy_rd : alu_sum;

   always_comb begin
      alu_ctrl.op       = (cnt_u && !cnt_v) ? cete_pkg::ALU_SUB : cete_pkg::ALU_ADD;
      alu_ctrl.use_best = state_ff == CAP_CHK;
   end

   cete_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_energy_ram (
      .clock   (clock),
      .wr_en   (energy_we),
      .wr_addr (load_addr),
      .wr_data (req_amount),
      .rd_addr (cnt_ff),
      .rd_data (energy_rd)
   );

   cete_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_we),
      .wr_addr (cnt_ff),
      .wr_data (alpha_wd),
      .rd_addr (cnt_ff),
      .rd_data (alpha_rd)
   );

   cete_alu u_alu (
      .ctrl   (alu_ctrl),
      .entry  (alpha_rd),
      .amount (amt_ff),
      .best   (best_ff),
      .sum    (alu_sum),
      .less   (alu_less)
   );

   always_comb begin
      state_in        = state_ff;
      size_in         = size_ff;
      cnt_in          = cnt_ff;
      tight_in        = tight_ff;
      cmd_in          = cmd_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      amt_in          = amt_ff;
      node_ok_in      = node_ok_ff;
      best_in         = best_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_capacity_in = rsp_capacity_ff;
      rsp_nonzero_in  = rsp_nonzero_ff;
      rsp_done_res_in = rsp_done_res_ff;

      if (csr_valid && csr_ready) begin
         size_in = csr_clique_size;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               cmd_in     = req_command;
               u_in       = req_from_node;
               v_in       = req_to_node;
               amt_in     = req_amount;
               node_ok_in = req_node_ok;
               cnt_in     = '0;
               best_in    = cete_pkg::DATA_MAX;
               priority if (req_command == cete_pkg::CMD_RESET) begin
                  state_in = COPY_RD;
               end else if ((req_command == cete_pkg::CMD_PUSH) && req_node_ok) begin
                  state_in = PUSH_RD;
               end else if ((req_command == cete_pkg::CMD_CAP) && req_node_ok) begin
                  state_in = CAP_RD;
               end else begin
                  state_in = FINISH;
               end
            end
         end
         COPY_RD: state_in = COPY_WR;
         COPY_WR, PUSH_WR: begin
            if (cnt_ff == full_mask) begin
               // restart tight sets, then scan from full-1 down to 1
               for (int i = 0; i < CLIQUE_MAX; i++) begin
                  tight_in[i] = full_mask;
               end
               cnt_in   = full_mask - AW'(1);
               state_in = SCAN_RD;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = (state_ff == COPY_WR) ? COPY_RD : PUSH_RD;
            end
         end
         SCAN_RD: state_in = SCAN_CHK;
         SCAN_CHK: begin
            // descending order: the last zero hit is the smallest set
            if (alpha_rd == '0) begin
               for (int i = 0; i < CLIQUE_MAX; i++) begin
                  if (full_mask[i] && cnt_ff[i]) begin
                     tight_in[i] = cnt_ff;
                  end
               end
            end
            if (cnt_ff == AW'(1)) begin
               state_in = FINISH;
            end else begin
               cnt_in   = cnt_ff - AW'(1);
               state_in = SCAN_RD;
            end
         end
         PUSH_RD: state_in = PUSH_WR;
         CAP_RD:  state_in = CAP_CHK;
         CAP_CHK: begin
            if (cnt_u && (!cnt_v || (u_ff == v_ff)) && alu_less) begin
               best_in = alpha_rd;
            end
            if (cnt_ff == full_mask) begin
               state_in = FINISH;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = CAP_RD;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_capacity_in = ((cmd_ff == cete_pkg::CMD_CAP) && node_ok_ff) ? best_ff : '0;
               rsp_nonzero_in  = (cmd_ff == cete_pkg::CMD_NZ) && node_ok_ff
                                 && tight_ff[u_idx][v_idx];
               rsp_done_res_in = cmd_ff <= cete_pkg::CMD_NZ;
               state_in        = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         size_ff      <= cete_pkg::CLIQUE_SIZE_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CLIQUE_MAX; i++) begin
            tight_ff[i] <= '1;
         end
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         tight_ff     <= tight_in;
      end
      cnt_ff          <= cnt_in;
      cmd_ff          <= cmd_in;
      u_ff            <= u_in;
      v_ff            <= v_in;
      amt_ff          <= amt_in;
      node_ok_ff      <= node_ok_in;
      best_ff         <= best_in;
      rsp_capacity_ff <= rsp_capacity_in;
      rsp_nonzero_ff  <= rsp_nonzero_in;
      rsp_done_res_ff <= rsp_done_res_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_capacity = rsp_capacity_ff;
   assign rsp_nonzero  = rsp_nonzero_ff;
   assign rsp_done_res = rsp_done_res_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("engine took a beat but did not go busy");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_RD || state_ff == SCAN_CHK) |-> (cnt_ff != '0 && cnt_ff != full_mask))
      else $error("tight scan left the open range of assignments");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == FINISH))
      else $error("result formed over a pending beat");

   a_cap_nodes_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CAP_RD || state_ff == CAP_CHK || state_ff == PUSH_WR) |-> node_ok_ff)
      else $error("table pass run with nodes out of range");
`endif

endmodule

@@ src/cete_ram.sv @@
module cete_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cete_alu.sv @@
module cete_alu (
   input  cete_pkg::alu_ctrl_type                  ctrl,
   input  logic signed [cete_pkg::DATA_W-1:0]      entry,
   input  logic signed [cete_pkg::DATA_W-1:0]      amount,
   input  logic signed [cete_pkg::DATA_W-1:0]      best,
   output logic signed [cete_pkg::DATA_W-1:0]      sum,
   output logic                                    less
);

   logic signed [cete_pkg::DATA_W-1:0] operand;

   always_comb begin
      operand = ctrl.use_best ? best : amount;
      unique case (ctrl.op)
         cete_pkg::ALU_ADD: sum = entry + operand;
         cete_pkg::ALU_SUB: sum = entry - operand;
         default:           sum = entry + operand;
      endcase
      less = entry < operand;
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int NODES          = cete_pkg::CLIQUE_MAX_DEF;
   localparam int DEPTH          = 1 << NODES;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int TAIL_CYCLES    = 200;
   localparam int PHASES         = 10;
   localparam int PHASE_BEATS    = 75;
   localparam int QUIET_PHASE    = 4;
   localparam logic [cete_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [cete_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   // clique sizes per random phase, first phase in the low bits
   localparam logic [cete_pkg::CSR_W*PHASES-1:0] SIZE_SEQ =
      {3'd3, 3'd4, 3'd5, 3'd0, 3'd7, 3'd1, 3'd6, 3'd4, 3'd2, 3'd3};
   localparam logic [cete_pkg::DATA_W-1:0] DATA_MIN = ~cete_pkg::DATA_MAX;

   typedef struct packed {
      logic signed [cete_pkg::DATA_W-1:0] capacity;
      logic                               nonzero;
      logic                               done_res;
   } arc_reply_type;

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_stall;
   logic [cete_pkg::CMD_W-1:0]     req_command     = '0;
   logic [cete_pkg::IDX_W-1:0]     req_entry_index = '0;
   logic [cete_pkg::NODE_W-1:0]    req_from_node   = '0;
   logic [cete_pkg::NODE_W-1:0]    req_to_node     = '0;
   logic [cete_pkg::DATA_W-1:0]    req_amount      = '0;
   logic                           rsp_valid;
   logic                           rsp_stall       = 1'b0;
   logic [cete_pkg::DATA_W-1:0]    rsp_capacity;
   logic                           rsp_nonzero;
   logic                           rsp_done_res;
   logic                           csr_valid       = 1'b0;
   logic                           csr_ready;
   logic [cete_pkg::CSR_W-1:0]     csr_clique_size = cete_pkg::CLIQUE_SIZE_RST;

   // shadow of the engine state
   logic [cete_pkg::DATA_W-1:0]    energy_mem [DEPTH];
   logic [cete_pkg::DATA_W-1:0]    alpha_mem  [DEPTH];
   logic [NODES-1:0]               tight_mem  [NODES];
   logic [cete_pkg::CSR_W-1:0]     size_reg = cete_pkg::CLIQUE_SIZE_RST;

   arc_reply_type        replies_due[$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   quiet = 1'b0;

   clique_energy_table_engine #(
      .CLIQUE_MAX(NODES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_from_node   (req_from_node),
      .req_to_node     (req_to_node),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_capacity    (rsp_capacity),
      .rsp_nonzero     (rsp_nonzero),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_clique_size (csr_clique_size)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < 38);
   end

   function automatic int node_limit();
      if (size_reg < cete_pkg::NODE_MIN) return int'(cete_pkg::NODE_MIN);
      if (size_reg > NODES) return NODES;
      return int'(size_reg);
   endfunction

   // smallest proper non-empty assignment with zero alpha holding each node
   function automatic void refresh_tight();
      int n;
      int full_set;
      n = node_limit();
      full_set = (1 << n) - 1;
      for (int i = 0; i < NODES; i++) tight_mem[i] = NODES'(full_set);
      for (int a = full_set - 1; a >= 1; a--) begin
         if (alpha_mem[a] == '0) begin
            for (int i = 0; i < n; i++) begin
               if (a[i]) tight_mem[i] = NODES'(a);
            end
         end
      end
   endfunction

   function automatic arc_reply_type predict_reply(
                                       input logic [cete_pkg::CMD_W-1:0] cmd,
                                       input logic [cete_pkg::IDX_W-1:0] idx,
                                       input logic [cete_pkg::NODE_W-1:0] u,
                                       input logic [cete_pkg::NODE_W-1:0] v,
                                       input logic [cete_pkg::DATA_W-1:0] amt);
      int n;
      int full_set;
      int um;
      int vm;
      int sub;
      bit in_range;
      logic signed [cete_pkg::DATA_W-1:0] lowest;
      arc_reply_type r;
      n = node_limit();
      full_set = (1 << n) - 1;
      in_range = (u < n) && (v < n);
      um = 1 << u;
      vm = 1 << v;
      sub = full_set & ~(um | vm);
      r = '0;
      r.done_res = 1'b1;
      case (cmd)
         cete_pkg::CMD_LOAD: energy_mem[idx] = amt;
         cete_pkg::CMD_RESET: begin
            for (int a = 0; a <= full_set; a++) alpha_mem[a] = energy_mem[a];
            refresh_tight();
         end
         cete_pkg::CMD_PUSH: begin
            if (in_range) begin
               // same node: both updates land on one entry and cancel
               for (int a = 0; a <= full_set; a++) begin
                  if ((a & ~sub) == 0) begin
                     alpha_mem[a | um] = alpha_mem[a | um] - amt;
                     alpha_mem[a | vm] = alpha_mem[a | vm] + amt;
                  end
               end
               refresh_tight();
            end
         end
         cete_pkg::CMD_CAP: begin
            if (in_range) begin
               lowest = cete_pkg::DATA_MAX;
               for (int a = 0; a <= full_set; a++) begin
                  if ((a & ~sub) == 0 && $signed(alpha_mem[a | um]) < lowest)
                     lowest = $signed(alpha_mem[a | um]);
               end
               r.capacity = lowest;
            end
         end
         cete_pkg::CMD_NZ: begin
            if (in_range) r.nonzero = tight_mem[u][v];
         end
         default: r.done_res = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [cete_pkg::DATA_W-1:0] pick_energy();
      int sel;
      sel = $urandom_range(9);
      if (sel < 3) return '0;
      if (sel < 5)
         return cete_pkg::DATA_W'($urandom_range(20)) - cete_pkg::DATA_W'(10);
      if (sel == 5) begin
         case ($urandom_range(2))
            0: return cete_pkg::DATA_MAX;
            1: return DATA_MIN;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // valid stays high on return; the caller either sends again at once or drains
   task automatic send_beat(input logic [cete_pkg::CMD_W-1:0] cmd,
                            input logic [cete_pkg::IDX_W-1:0] idx,
                            input logic [cete_pkg::NODE_W-1:0] u,
                            input logic [cete_pkg::NODE_W-1:0] v,
                            input logic [cete_pkg::DATA_W-1:0] amt);
      while (!quiet && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_entry_index <= idx;
      req_from_node   <= u;
      req_to_node     <= v;
      req_amount      <= amt;
      do @(posedge clock); while (req_stall);
      replies_due.insert(replies_due.size(), predict_reply(cmd, idx, u, v, amt));
   endtask

   // an empty queue means valid was already dropped
   task automatic wait_drained();
      if (replies_due.size() != 0) begin
         req_valid <= 1'b0;
         while (replies_due.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_size(input logic [cete_pkg::CSR_W-1:0] value);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_clique_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
   endtask

   task automatic check_field(input string name,
                              input logic [cete_pkg::DATA_W-1:0] want,
                              input logic [cete_pkg::DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_replies
      arc_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            error_count++;
            $error("result beat with nothing pending");
         end else begin
            want = replies_due[0];
            replies_due.delete(0);
            check_field("capacity", want.capacity, rsp_capacity);
            check_field("nonzero", cete_pkg::DATA_W'(want.nonzero),
                        cete_pkg::DATA_W'(rsp_nonzero));
            check_field("done_res", cete_pkg::DATA_W'(want.done_res),
                        cete_pkg::DATA_W'(rsp_done_res));
         end
      end
   end

   // tight sets still at their reset value; nothing here reads the tables
   task automatic test_reset_state();
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd0, 2'd1, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd1, 2'd1, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd3, 2'd0, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd0, 2'd2, '0);
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd2, 2'd0, '0);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd0, 2'd3, cete_pkg::DATA_W'(5));
      send_beat(CMD_SPARE_LO, 4'hf, 2'd3, 2'd3, '1);
      send_beat(CMD_SPARE_HI, 4'h0, 2'd0, 2'd0, '0);
   endtask

   // every entry written at full size so no later read hits an unwritten one
   task automatic test_table_fill();
      logic [cete_pkg::DATA_W-1:0] value;
      write_size(3'd4);
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            3, 9, 12: value = '0;
            5:        value = cete_pkg::DATA_MAX;
            6:        value = DATA_MIN;
            10:       value = '1;
            default:  value = $urandom;
         endcase
         send_beat(cete_pkg::CMD_LOAD, cete_pkg::IDX_W'(i), 2'd0, 2'd0, value);
      end
      send_beat(cete_pkg::CMD_RESET, 4'd0, 2'd0, 2'd0, '0);
   endtask

   task automatic test_arc_cases();
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd0, 2'd1, '0);
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd3, 2'd2, '0);
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd2, 2'd2, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd0, 2'd3, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd3, 2'd3, '0);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd1, 2'd2, cete_pkg::DATA_MAX);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd2, 2'd1, DATA_MIN);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd0, 2'd0, cete_pkg::DATA_W'(7));
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd1, 2'd2, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd1, 2'd2, '0);
      send_beat(cete_pkg::CMD_LOAD, 4'hf, 2'd0, 2'd0, '0);
      send_beat(cete_pkg::CMD_RESET, 4'd0, 2'd0, 2'd0, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd2, 2'd0, '0);
   endtask

   // tight sets keep their old contents across a size change until rescanned
   task automatic test_size_settings();
      write_size(3'd2);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd0, 2'd1, '0);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd0, 2'd3, '0);
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd1, 2'd0, '0);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd0, 2'd1, cete_pkg::DATA_W'(3));
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd1, 2'd0, '0);
      write_size(3'd0);
      send_beat(cete_pkg::CMD_PUSH, 4'd0, 2'd1, 2'd0, cete_pkg::DATA_W'(3));
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd0, 2'd1, '0);
      send_beat(cete_pkg::CMD_RESET, 4'd0, 2'd0, 2'd0, '0);
      write_size(3'd7);
      send_beat(cete_pkg::CMD_NZ, 4'd0, 2'd3, 2'd1, '0);
      send_beat(cete_pkg::CMD_CAP, 4'd0, 2'd3, 2'd0, '0);
      send_beat(cete_pkg::CMD_RESET, 4'd0, 2'd0, 2'd0, '0);
   endtask

   function automatic logic [cete_pkg::CMD_W-1:0] CMD_WIDTH_SPARE();
      return cete_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
   endfunction

   function automatic logic [cete_pkg::NODE_W-1:0] u_rand();
      return cete_pkg::NODE_W'($urandom);
   endfunction

   task automatic random_beat();
      int n;
      int roll;
      int sel;
      int sub;
      logic [cete_pkg::NODE_W-1:0] u;
      logic [cete_pkg::NODE_W-1:0] v;
      logic [cete_pkg::DATA_W-1:0] amt;
      logic [cete_pkg::CMD_W-1:0]  cmd;
      n = node_limit();
      sel = $urandom_range(99);
      if (sel < 15) begin
         u = cete_pkg::NODE_W'($urandom);
         v = cete_pkg::NODE_W'($urandom);
      end else begin
         u = cete_pkg::NODE_W'($urandom_range(n - 1));
         if (sel < 30) v = u;
         else v = cete_pkg::NODE_W'((int'(u) + $urandom_range(n - 1, 1)) % n);
      end
      amt = $urandom;
      if ($urandom_range(49) == 0) wait_drained();
      roll = $urandom_range(99);
      if (roll < 18) begin
         cmd = cete_pkg::CMD_LOAD;
         amt = pick_energy();
      end else if (roll < 26) begin
         cmd = cete_pkg::CMD_RESET;
      end else if (roll < 56) begin
         cmd = cete_pkg::CMD_PUSH;
         sel = $urandom_range(9);
         if (sel < 5) begin
            amt = $urandom_range(1000, 1);
         end else if (sel < 7) begin
            // drive one entry to zero so the tight sets move
            sub = ((1 << n) - 1) & ~((1 << u) | (1 << v));
            amt = alpha_mem[(int'($urandom) & sub) | (1 << u)];
         end
      end else if (roll < 76) begin
         cmd = cete_pkg::CMD_CAP;
      end else if (roll < 95) begin
         cmd = cete_pkg::CMD_NZ;
      end else begin
         cmd = CMD_WIDTH_SPARE();
      end
      send_beat(cmd, cete_pkg::IDX_W'($urandom), u, v, amt);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < PHASES; p++) begin
         write_size(SIZE_SEQ[cete_pkg::CSR_W*p +: cete_pkg::CSR_W]);
         quiet = (p == QUIET_PHASE);
         for (int k = 0; k < 4; k++)
            send_beat(cete_pkg::CMD_LOAD, cete_pkg::IDX_W'($urandom), u_rand(), u_rand(),
                      pick_energy());
         send_beat(cete_pkg::CMD_RESET, cete_pkg::IDX_W'($urandom), u_rand(), u_rand(),
                   cete_pkg::DATA_W'($urandom));
         for (int k = 0; k < PHASE_BEATS; k++) random_beat();
      end
      quiet = 1'b0;
   endtask

   task automatic finish_run();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) tight_mem[i] = '1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_table_fill();
      test_arc_cases();
      test_size_settings();
      test_random_traffic();
      finish_run();
   end

endmodule
